### design/zpw_pkg.sv
// ----------------------------------------------------------------------------
// zpw_pkg
// shared types and constants of the zone proximity weighting core
// ----------------------------------------------------------------------------
package zpw_pkg;

    localparam int NUM_ZONES_DEF = 16;

    localparam int POS_W   = 32;
    localparam int EXT_W   = 31;
    localparam int SLOT_W  = 4;
    localparam int WGT_W   = 17;
    localparam int OFS_W   = 33;
    localparam int SQ_W    = 62;
    localparam int SUM_W   = 64;
    localparam int ROOT_W  = 32;

    // input item kinds carried on tuser
    localparam logic [1:0] FUNC_REG    = 2'd0;
    localparam logic [1:0] FUNC_REMOVE = 2'd1;
    localparam logic [1:0] FUNC_TICK   = 2'd2;

    localparam logic SHAPE_SPHERE = 1'b0;
    localparam logic SHAPE_BOX    = 1'b1;

    typedef struct packed {
        logic             shape;
        logic [POS_W-1:0] cx;
        logic [POS_W-1:0] cy;
        logic [POS_W-1:0] cz;
        logic [EXT_W-1:0] ex;
        logic [EXT_W-1:0] ey;
        logic [EXT_W-1:0] ez;
    } zone_t;

endpackage

### design/zpw_table.sv
// ----------------------------------------------------------------------------
// zpw_table
// zone parameter memory, one write port and one registered read port
// ----------------------------------------------------------------------------
module zpw_table #(
    parameter int NUM_ZONES = zpw_pkg::NUM_ZONES_DEF,
    parameter int SW        = 4
) (
    input  logic            aclk,
    input  logic            wr_en,
    input  logic [SW-1:0]   wr_addr,
    input  zpw_pkg::zone_t  wr_data,
    input  logic [SW-1:0]   rd_addr,
    output zpw_pkg::zone_t  rd_data
);

    zpw_pkg::zone_t mem_reg [NUM_ZONES];
    zpw_pkg::zone_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

### design/zpw_sq.sv
// ----------------------------------------------------------------------------
// zpw_sq
// bit-serial squarer, one multiplier bit per cycle
// ----------------------------------------------------------------------------
module zpw_sq (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [zpw_pkg::EXT_W-1:0]  a,
    output logic                       busy,
    output logic [zpw_pkg::SQ_W-1:0]   prod
);

    logic [zpw_pkg::EXT_W-1:0] mplier_reg;
    logic [zpw_pkg::SQ_W-1:0]  mcand_reg;
    logic [zpw_pkg::SQ_W-1:0]  acc_reg;
    logic [4:0]                cnt_reg;
    logic                      busy_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + 5'd1;
            if (cnt_reg == 5'(zpw_pkg::EXT_W - 1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            mplier_reg <= a;
            mcand_reg  <= zpw_pkg::SQ_W'(a);
            acc_reg    <= '0;
        end else if (busy_reg) begin
            if (mplier_reg[0]) begin
                acc_reg <= acc_reg + mcand_reg;
            end
            mplier_reg <= mplier_reg >> 1;
            mcand_reg  <= mcand_reg << 1;
        end
    end

    assign busy = busy_reg;
    assign prod = acc_reg;

endmodule

### design/zpw_sqrt.sv
// ----------------------------------------------------------------------------
// zpw_sqrt
// digit-by-digit integer square root, two radicand bits per cycle
// ----------------------------------------------------------------------------
module zpw_sqrt (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [zpw_pkg::SUM_W-1:0]   n,
    output logic                        busy,
    output logic [zpw_pkg::ROOT_W-1:0]  root
);

    logic [zpw_pkg::SUM_W-1:0]  rad_reg;
    logic [33:0]                rem_reg;
    logic [zpw_pkg::ROOT_W-1:0] root_reg;
    logic [4:0]                 cnt_reg;
    logic                       busy_reg;
    logic [35:0]                rem_sh;
    logic [35:0]                trial;

    assign rem_sh = {rem_reg, rad_reg[zpw_pkg::SUM_W-1 -: 2]};
    assign trial  = {2'b00, root_reg, 2'b01};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + 5'd1;
            if (cnt_reg == 5'd31) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rad_reg  <= n;
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (busy_reg) begin
            rad_reg <= rad_reg << 2;
            if (rem_sh >= trial) begin
                rem_reg  <= 34'(rem_sh - trial);
                root_reg <= {root_reg[zpw_pkg::ROOT_W-2:0], 1'b1};
            end else begin
                rem_reg  <= rem_sh[33:0];
                root_reg <= {root_reg[zpw_pkg::ROOT_W-2:0], 1'b0};
            end
        end
    end

    assign busy = busy_reg;
    assign root = root_reg;

endmodule

### design/zpw_div.sv
// ----------------------------------------------------------------------------
// zpw_div
// restoring divider for num * 65536 / den with num <= den, one bit per cycle
// ----------------------------------------------------------------------------
module zpw_div (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [zpw_pkg::EXT_W-1:0]  num,
    input  logic [zpw_pkg::EXT_W-1:0]  den,
    output logic                       busy,
    output logic [zpw_pkg::WGT_W-1:0]  quo
);

    logic [31:0]               rem_reg;
    logic [zpw_pkg::EXT_W-1:0] den_reg;
    logic [zpw_pkg::WGT_W-1:0] quo_reg;
    logic [4:0]                cnt_reg;
    logic                      busy_reg;
    logic [31:0]               den_ext;

    assign den_ext = {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + 5'd1;
            if (cnt_reg == 5'(zpw_pkg::WGT_W - 1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= {1'b0, num};
            den_reg <= den;
            quo_reg <= '0;
        end else if (busy_reg) begin
            if (rem_reg >= den_ext) begin
                rem_reg <= (rem_reg - den_ext) << 1;
                quo_reg <= {quo_reg[zpw_pkg::WGT_W-2:0], 1'b1};
            end else begin
                rem_reg <= rem_reg << 1;
                quo_reg <= {quo_reg[zpw_pkg::WGT_W-2:0], 1'b0};
            end
        end
    end

    assign busy = busy_reg;
    assign quo  = quo_reg;

endmodule

### design/zone_proximity_weighting_core.sv
// ----------------------------------------------------------------------------
// zone_proximity_weighting_core
// zone table with register, remove and listener tick; per-zone Q1.16 weights
// ----------------------------------------------------------------------------
//
// channel | dir | handshake         | payload
// --------+-----+-------------------+---------------------------------------
// s_      | in  | s_tvalid/s_tready | tuser func, tdata slot/shape/pos/ext
// m_      | out | m_tvalid/m_tready | tdata result fields, tlast end of item
//
// register and remove items give one result in the cycle after acceptance
// a tick walks every slot; an empty slot passes through the read, offset and emit
// steps, a zone known to weigh zero adds a prep step, a box zone runs three
// dividers in parallel, a sphere zone runs three squarers in parallel, then the
// root, then one divider in series
// reset clears the occupancy and activity flags; zone parameters are not reset
// an item is taken only while the walker is idle and the result register can
// be loaded; a stalled result register holds the walker in its emit step
//
module zone_proximity_weighting_core #(
    parameter int NUM_ZONES = zpw_pkg::NUM_ZONES_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // slot[3:0] shape[4] pos_x[36:5] pos_y[68:37] pos_z[100:69]
    // ext_x[131:101] ext_y[162:132] ext_z[193:163]
    input  logic [199:0] s_tdata,
    // func[1:0]
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // out_slot[3:0] zone_present[4] weight[21:5] active[22] entered[23]
    // exited[24] accepted[25]
    output logic [31:0]  m_tdata,
    output logic         m_tlast
);

    localparam int SW = (NUM_ZONES > 1) ? $clog2(NUM_ZONES) : 1;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_READ = 4'd1;
    localparam logic [3:0] ST_OFFS = 4'd2;
    localparam logic [3:0] ST_PREP = 4'd3;
    localparam logic [3:0] ST_SQR  = 4'd4;
    localparam logic [3:0] ST_SUM  = 4'd5;
    localparam logic [3:0] ST_ROOT = 4'd6;
    localparam logic [3:0] ST_DIV  = 4'd7;
    localparam logic [3:0] ST_EMIT = 4'd8;

    localparam int OW = zpw_pkg::OFS_W;
    localparam int EW = zpw_pkg::EXT_W;
    localparam int PW = zpw_pkg::POS_W;

    // input field unpacking
    logic [3:0]    in_slot;
    logic          in_shape;
    logic [PW-1:0] in_px, in_py, in_pz;
    logic [EW-1:0] in_ex, in_ey, in_ez;
    logic [6:0]    in_slot_ext;
    logic          in_inside;
    logic [SW-1:0] in_idx;

    assign in_slot  = s_tdata[3:0];
    assign in_shape = s_tdata[4];
    assign in_px    = s_tdata[36:5];
    assign in_py    = s_tdata[68:37];
    assign in_pz    = s_tdata[100:69];
    assign in_ex    = s_tdata[131:101];
    assign in_ey    = s_tdata[162:132];
    assign in_ez    = s_tdata[193:163];

    assign in_slot_ext = {3'b000, in_slot};
    assign in_inside   = in_slot_ext < 7'(NUM_ZONES);
    assign in_idx      = in_slot_ext[SW-1:0];

    // control state
    logic [3:0]           state_reg, state_next;
    logic [SW-1:0]        k_reg, k_next;
    logic [NUM_ZONES-1:0] used_reg, used_next;
    logic [NUM_ZONES-1:0] prior_reg, prior_next;
    logic                 ovalid_reg, ovalid_next;

    // datapath registers
    logic [PW-1:0]              lx_reg, ly_reg, lz_reg;
    logic [OW-1:0]              ax_reg, ay_reg, az_reg;
    logic [OW-1:0]              ax_next, ay_next, az_next;
    logic [zpw_pkg::SUM_W-1:0]  sum_reg, sum_next;
    logic [zpw_pkg::WGT_W-1:0]  w_reg, w_next;
    logic [31:0]                odata_reg, odata_next;
    logic                       olast_reg, olast_next;

    logic           accept, out_free;
    logic           tbl_wr;
    zpw_pkg::zone_t tbl_wdata, zone;

    logic sq_start, sqrt_start, div_start_s, div_start_b;
    logic [2:0] sq_busy, div_busy;
    logic sqrt_busy;
    logic [zpw_pkg::SQ_W-1:0]   sq_prod [3];
    logic [zpw_pkg::ROOT_W-1:0] root;
    logic [zpw_pkg::WGT_W-1:0]  quo [3];
    logic [EW-1:0] div_num [3];
    logic [EW-1:0] div_den [3];

    assign out_free = !ovalid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && out_free;
    assign accept   = s_tvalid && s_tready;

    assign tbl_wr = accept && (s_tuser == zpw_pkg::FUNC_REG) && in_inside
                    && !used_reg[in_idx];
    assign tbl_wdata = '{shape: in_shape, cx: in_px, cy: in_py, cz: in_pz,
                         ex: in_ex, ey: in_ey, ez: in_ez};

    zpw_table #(.NUM_ZONES(NUM_ZONES), .SW(SW)) u_table (
        .aclk    (aclk),
        .wr_en   (tbl_wr),
        .wr_addr (in_idx),
        .wr_data (tbl_wdata),
        .rd_addr (k_reg),
        .rd_data (zone)
    );

    // per-axis magnitude of listener minus centre
    function automatic logic [zpw_pkg::OFS_W-1:0] abs_off(
        input logic [zpw_pkg::POS_W-1:0] p, input logic [zpw_pkg::POS_W-1:0] c);
        logic [zpw_pkg::OFS_W-1:0] d;
        d = {p[zpw_pkg::POS_W-1], p} - {c[zpw_pkg::POS_W-1], c};
        return d[zpw_pkg::OFS_W-1] ? (~d + 1'b1) : d;
    endfunction

    logic [OW-1:0] hx_ext, hy_ext, hz_ext;
    logic          sph_zero, box_zero;

    assign hx_ext = {2'b00, zone.ex};
    assign hy_ext = {2'b00, zone.ey};
    assign hz_ext = {2'b00, zone.ez};

    // sphere is empty when the radius is zero or any axis offset already reaches it
    assign sph_zero = (zone.ex == '0) || (ax_reg >= hx_ext) || (ay_reg >= hx_ext)
                      || (az_reg >= hx_ext);
    // box is empty when any half-extent is zero or the listener is outside
    assign box_zero = (zone.ex == '0) || (zone.ey == '0) || (zone.ez == '0)
                      || (ax_reg > hx_ext) || (ay_reg > hy_ext) || (az_reg > hz_ext);

    // squarer lanes, one per axis
    logic [EW-1:0] sq_in [3];
    assign sq_in[0] = ax_reg[EW-1:0];
    assign sq_in[1] = ay_reg[EW-1:0];
    assign sq_in[2] = az_reg[EW-1:0];

    // divider operands: lane 0 serves the sphere, all lanes serve the box
    assign div_num[0] = (zone.shape == zpw_pkg::SHAPE_SPHERE)
                        ? EW'(zone.ex - root[EW-1:0])
                        : EW'(zone.ex - ax_reg[EW-1:0]);
    assign div_num[1] = EW'(zone.ey - ay_reg[EW-1:0]);
    assign div_num[2] = EW'(zone.ez - az_reg[EW-1:0]);
    assign div_den[0] = zone.ex;
    assign div_den[1] = zone.ey;
    assign div_den[2] = zone.ez;

    for (genvar g = 0; g < 3; g++) begin : g_lane
        zpw_sq u_sq (
            .aclk    (aclk),
            .aresetn (aresetn),
            .start   (sq_start),
            .a       (sq_in[g]),
            .busy    (sq_busy[g]),
            .prod    (sq_prod[g])
        );
        zpw_div u_div (
            .aclk    (aclk),
            .aresetn (aresetn),
            .start   (div_start_b || (div_start_s && (g == 0))),
            .num     (div_num[g]),
            .den     (div_den[g]),
            .busy    (div_busy[g]),
            .quo     (quo[g])
        );
    end

    zpw_sqrt u_sqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (sqrt_start),
        .n       (sum_reg),
        .busy    (sqrt_busy),
        .root    (root)
    );

    logic [zpw_pkg::WGT_W-1:0] qmin01, qmin;
    assign qmin01 = (quo[1] < quo[0]) ? quo[1] : quo[0];
    assign qmin   = (quo[2] < qmin01) ? quo[2] : qmin01;

    logic       act_now, was_act, k_used, k_last;
    logic [3:0] k_slot;
    logic [6:0] k_ext;

    assign k_ext   = 7'(k_reg);
    assign k_slot  = k_ext[3:0];
    assign k_used  = used_reg[k_reg];
    assign was_act = prior_reg[k_reg];
    assign act_now = k_used && (w_reg != '0);
    assign k_last  = k_ext == 7'(NUM_ZONES - 1);

    always_comb begin
        state_next  = state_reg;
        k_next      = k_reg;
        used_next   = used_reg;
        prior_next  = prior_reg;
        ovalid_next = ovalid_reg && !m_tready;
        odata_next  = odata_reg;
        olast_next  = olast_reg;
        ax_next     = ax_reg;
        ay_next     = ay_reg;
        az_next     = az_reg;
        sum_next    = sum_reg;
        w_next      = w_reg;
        sq_start    = 1'b0;
        sqrt_start  = 1'b0;
        div_start_s = 1'b0;
        div_start_b = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (s_tuser)
                        zpw_pkg::FUNC_REG: begin
                            // slot[3:0] present[4] accepted[25]
                            ovalid_next = 1'b1;
                            olast_next  = 1'b1;
                            odata_next  = {6'd0, tbl_wr, 3'd0, 17'd0, in_inside, in_slot};
                            if (tbl_wr) begin
                                used_next[in_idx]  = 1'b1;
                                prior_next[in_idx] = 1'b0;
                            end
                        end
                        zpw_pkg::FUNC_REMOVE: begin
                            ovalid_next = 1'b1;
                            olast_next  = 1'b1;
                            odata_next  = {6'd0, in_inside && used_reg[in_idx], 3'd0,
                                           17'd0, 1'b0, in_slot};
                            if (in_inside) begin
                                used_next[in_idx]  = 1'b0;
                                prior_next[in_idx] = 1'b0;
                            end
                        end
                        zpw_pkg::FUNC_TICK: begin
                            k_next     = '0;
                            state_next = ST_READ;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_READ: begin
                // table read of slot k lands next cycle
                state_next = ST_OFFS;
            end
            ST_OFFS: begin
                ax_next = abs_off(lx_reg, zone.cx);
                ay_next = abs_off(ly_reg, zone.cy);
                az_next = abs_off(lz_reg, zone.cz);
                w_next  = '0;
                state_next = k_used ? ST_PREP : ST_EMIT;
            end
            ST_PREP: begin
                if (zone.shape == zpw_pkg::SHAPE_SPHERE) begin
                    if (sph_zero) begin
                        state_next = ST_EMIT;
                    end else begin
                        sq_start   = 1'b1;
                        state_next = ST_SQR;
                    end
                end else begin
                    if (box_zero) begin
                        state_next = ST_EMIT;
                    end else begin
                        div_start_b = 1'b1;
                        state_next  = ST_DIV;
                    end
                end
            end
            ST_SQR: begin
                if (sq_busy == 3'b000) begin
                    sum_next = zpw_pkg::SUM_W'(sq_prod[0]) + zpw_pkg::SUM_W'(sq_prod[1])
                               + zpw_pkg::SUM_W'(sq_prod[2]);
                    state_next = ST_SUM;
                end
            end
            ST_SUM: begin
                sqrt_start = 1'b1;
                state_next = ST_ROOT;
            end
            ST_ROOT: begin
                if (!sqrt_busy) begin
                    if (root >= {1'b0, zone.ex}) begin
                        state_next = ST_EMIT;
                    end else begin
                        div_start_s = 1'b1;
                        state_next  = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                if (div_busy == 3'b000) begin
                    w_next = (zone.shape == zpw_pkg::SHAPE_SPHERE) ? quo[0] : qmin;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    ovalid_next = 1'b1;
                    olast_next  = k_last;
                    odata_next  = {6'd0, 1'b0, k_used && !act_now && was_act,
                                   act_now && !was_act, act_now,
                                   k_used ? w_reg : 17'd0, k_used, k_slot};
                    if (k_used) begin
                        prior_next[k_reg] = act_now;
                    end
                    if (k_last) begin
                        state_next = ST_IDLE;
                    end else begin
                        k_next     = k_reg + 1'b1;
                        state_next = ST_READ;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            k_reg      <= '0;
            used_reg   <= '0;
            prior_reg  <= '0;
            ovalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            k_reg      <= k_next;
            used_reg   <= used_next;
            prior_reg  <= prior_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            lx_reg <= in_px;
            ly_reg <= in_py;
            lz_reg <= in_pz;
        end
        ax_reg    <= ax_next;
        ay_reg    <= ay_next;
        az_reg    <= az_next;
        sum_reg   <= sum_next;
        w_reg     <= w_next;
        odata_reg <= odata_next;
        olast_reg <= olast_next;
    end

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = odata_reg;
    assign m_tlast  = olast_reg;

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// zone table register/remove/tick checks against a built-in weight predictor
// ----------------------------------------------------------------------------
module testbench;

    localparam int NZ        = 16;
    localparam int CYCLE_CAP = 10000000;

    localparam logic [1:0] F_REG     = zpw_pkg::FUNC_REG;
    localparam logic [1:0] F_REMOVE  = zpw_pkg::FUNC_REMOVE;
    localparam logic [1:0] F_TICK    = zpw_pkg::FUNC_TICK;
    localparam logic [1:0] F_UNUSED  = 2'd3;
    localparam logic       SH_SPHERE = zpw_pkg::SHAPE_SPHERE;
    localparam logic       SH_BOX    = zpw_pkg::SHAPE_BOX;

    typedef struct packed {
        logic [3:0]  slot;
        logic        present;
        logic [16:0] weight;
        logic        active;
        logic        entered;
        logic        exited;
        logic        accepted;
        logic        last;
    } zres_t;

    typedef struct {
        logic [1:0]  func;
        logic [3:0]  slot;
        logic        shape;
        logic [31:0] px, py, pz;
        logic [30:0] ex, ey, ez;
        logic        has_exp;
        zres_t       exp_res;
    } zitem_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [199:0] s_tdata = '0;
    logic [1:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic m_tlast;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    zone_proximity_weighting_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    // predictor copy of the zone table
    logic        used_q [NZ];
    logic        shape_q[NZ];
    logic [31:0] cx_q[NZ], cy_q[NZ], cz_q[NZ];
    logic [30:0] ex_q[NZ], ey_q[NZ], ez_q[NZ];
    logic        was_act[NZ];

    zres_t  expected_q[$];
    zitem_t items[$];
    int     errors = 0;
    int     cycles = 0;

    task automatic add_expected(zres_t r);
        expected_q = {expected_q, r};
    endtask

    task automatic add_item(zitem_t it);
        items = {items, it};
    endtask

    function automatic longint unsigned abs_off(logic [31:0] a, logic [31:0] b);
        longint d;
        d = longint'(signed'(a)) - longint'(signed'(b));
        return d < 0 ? longint'(-d) : d;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic logic [16:0] axis_wgt(longint unsigned off, longint unsigned half);
        if (half == 0 || off > half) return '0;
        return 17'(((half - off) << 16) / half);
    endfunction

    function automatic logic [16:0] zone_wgt(int s, logic [31:0] x, logic [31:0] y,
                                             logic [31:0] z);
        longint unsigned ax, ay, az, h, d;
        logic [16:0] w, t;
        ax = abs_off(x, cx_q[s]);
        ay = abs_off(y, cy_q[s]);
        az = abs_off(z, cz_q[s]);
        h = ex_q[s];
        if (shape_q[s] == SH_SPHERE) begin
            if (h == 0 || ax >= h || ay >= h || az >= h) return '0;
            d = int_sqrt(ax * ax + ay * ay + az * az);
            if (d >= h) return '0;
            return 17'(((h - d) << 16) / h);
        end
        w = axis_wgt(ax, h);
        t = axis_wgt(ay, ey_q[s]);
        if (t < w) w = t;
        t = axis_wgt(az, ez_q[s]);
        if (t < w) w = t;
        return w;
    endfunction

    // apply one accepted transaction to the predictor, queue its results
    task automatic predict_zone_results(zitem_t it);
        zres_t r;
        logic [16:0] w;
        r = '0;
        r.slot = it.slot;
        r.last = 1'b1;
        case (it.func)
            F_REG: begin
                if (!used_q[it.slot]) begin
                    used_q[it.slot] = 1'b1;
                    shape_q[it.slot] = it.shape;
                    cx_q[it.slot] = it.px; cy_q[it.slot] = it.py; cz_q[it.slot] = it.pz;
                    ex_q[it.slot] = it.ex; ey_q[it.slot] = it.ey; ez_q[it.slot] = it.ez;
                    was_act[it.slot] = 1'b0;
                    r.accepted = 1'b1;
                end
                r.present = 1'b1;
                add_expected(r);
            end
            F_REMOVE: begin
                if (used_q[it.slot]) begin
                    used_q[it.slot] = 1'b0;
                    was_act[it.slot] = 1'b0;
                    r.accepted = 1'b1;
                end
                add_expected(r);
            end
            F_TICK: begin
                for (int k = 0; k < NZ; k++) begin
                    r = '0;
                    r.slot = 4'(k);
                    r.last = (k == NZ - 1);
                    if (used_q[k]) begin
                        w = zone_wgt(k, it.px, it.py, it.pz);
                        r.present = 1'b1;
                        r.weight = w;
                        r.active = (w != 0);
                        r.entered = r.active && !was_act[k];
                        r.exited = !r.active && was_act[k];
                        was_act[k] = r.active;
                    end
                    add_expected(r);
                end
            end
            default: ;
        endcase
    endtask

    function automatic zitem_t mk(logic [1:0] f, logic [3:0] s, logic sh,
                                  logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                  logic [30:0] a, logic [30:0] b, logic [30:0] c);
        zitem_t it;
        it.func = f; it.slot = s; it.shape = sh;
        it.px = x; it.py = y; it.pz = z;
        it.ex = a; it.ey = b; it.ez = c;
        it.has_exp = 1'b0;
        it.exp_res = '0;
        return it;
    endfunction

    function automatic zitem_t mk_exp(zitem_t it, logic pres, logic acc);
        it.has_exp = 1'b1;
        it.exp_res = '0;
        it.exp_res.slot = it.slot;
        it.exp_res.present = pres;
        it.exp_res.accepted = acc;
        it.exp_res.last = 1'b1;
        return it;
    endfunction

    localparam logic [31:0] ONE  = 32'h0001_0000;
    localparam logic [31:0] PMAX = 32'h7FFF_FFFF;
    localparam logic [31:0] PMIN = 32'h8000_0000;
    localparam logic [30:0] EMAX = 31'h7FFF_FFFF;

    task automatic build_directed();
        // remove from empty slot after reset: not accepted
        add_item(mk_exp(mk(F_REMOVE, 4'd3, 0, 0, 0, 0, 0, 0, 0), 0, 0));
        // tick on empty table
        add_item(mk(F_TICK, 0, 0, PMAX, PMIN, 0, 0, 0, 0));
        add_item(mk_exp(mk(F_REG, 4'd0, SH_SPHERE, 0, 0, 0,
                           31'(4 * ONE), 0, 0), 1, 1));
        // register into occupied slot: refused
        add_item(mk_exp(mk(F_REG, 4'd0, SH_BOX, 0, 0, 0, 1, 1, 1), 1, 0));
        add_item(mk_exp(mk(F_REG, 4'd15, SH_BOX, PMIN, PMIN, PMIN,
                           EMAX, EMAX, EMAX), 1, 1));
        add_item(mk_exp(mk(F_REG, 4'd1, SH_SPHERE, PMAX, PMAX, PMAX,
                           0, EMAX, EMAX), 1, 1));   // zero radius
        add_item(mk_exp(mk(F_REG, 4'd2, SH_BOX, 0, 0, 0,
                           31'(ONE), 0, 31'(ONE)), 1, 1)); // zero half-extent
        add_item(mk_exp(mk(F_REG, 4'd3, SH_BOX, ONE, 0, 0,
                           31'(2 * ONE), 31'(ONE), 31'(ONE)), 1, 1));
        // listener at the slot 0 centre: full weight, entered
        add_item(mk(F_TICK, 0, 0, 0, 0, 0, 0, 0, 0));
        add_item(mk(F_TICK, 0, 0, ONE, 0, 0, 0, 0, 0));
        // far away: exits
        add_item(mk(F_TICK, 0, 0, PMAX, PMAX, PMAX, 0, 0, 0));
        add_item(mk(F_TICK, 0, 0, PMIN, PMIN, PMIN, 0, 0, 0));
        add_item(mk(F_TICK, 0, 0, 32'(3 * ONE), 0, 0, 0, 0, 0));
        // removal of a registered zone that has already exited: accepted, no exit event
        add_item(mk_exp(mk(F_REMOVE, 4'd15, 0, 0, 0, 0, 0, 0, 0), 0, 1));
        add_item(mk(F_TICK, 0, 0, 0, 0, 0, 0, 0, 0));
        // unused func code: ignored
        add_item(mk(F_UNUSED, 4'd5, 1, PMAX, PMIN, PMAX, EMAX, EMAX, EMAX));
        add_item(mk_exp(mk(F_REG, 4'd15, SH_SPHERE, 0, 0, 0,
                           EMAX, 0, 0), 1, 1));
        add_item(mk(F_TICK, 0, 0, PMAX, PMAX, PMAX, 0, 0, 0));
        add_item(mk(F_TICK, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 0, 0, 0));
        for (int s = 0; s < NZ; s++)
            add_item(mk(F_REMOVE, 4'(s), 0, 0, 0, 0, 0, 0, 0));
    endtask

    function automatic logic [31:0] rnd_pos();
        case ($urandom_range(0, 4))
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 16 * 65536)) - 8 * 65536);
            default: return 32'($signed($urandom_range(0, 64 * 65536)) - 32 * 65536);
        endcase
    endfunction

    function automatic logic [30:0] rnd_ext();
        case ($urandom_range(0, 9))
            0: return 31'($urandom());
            1: return 31'($urandom_range(0, 3));
            default: return 31'($urandom_range(1, 40 * 65536));
        endcase
    endfunction

    task automatic build_random();
        int pick;
        for (int i = 0; i < 400; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 35)
                add_item(mk(F_REG, 4'($urandom()), 1'($urandom()),
                            rnd_pos(), rnd_pos(), rnd_pos(),
                            rnd_ext(), rnd_ext(), rnd_ext()));
            else if (pick < 50)
                add_item(mk(F_REMOVE, 4'($urandom()), 1'($urandom()),
                            $urandom(), $urandom(), $urandom(),
                            31'($urandom()), 31'($urandom()), 31'($urandom())));
            else if (pick < 97)
                add_item(mk(F_TICK, 4'($urandom()), 1'($urandom()),
                            rnd_pos(), rnd_pos(), rnd_pos(),
                            31'($urandom()), 31'($urandom()), 31'($urandom())));
            else
                add_item(mk(F_UNUSED, 4'($urandom()), 1'($urandom()),
                            $urandom(), $urandom(), $urandom(),
                            31'($urandom()), 31'($urandom()), 31'($urandom())));
        end
    endtask

    function automatic int gap_len();
        if ($urandom_range(0, 9) == 0) return $urandom_range(20, 200);
        if ($urandom_range(0, 2) == 0) return 0;
        return $urandom_range(0, 3);
    endfunction

    bit sent_all = 1'b0;

    // source side: present items, random gaps, none before items 41 to 89
    initial begin
        zitem_t it;
        int g;
        build_directed();
        build_random();
        for (int i = 0; i < NZ; i++) begin
            used_q[i] = 1'b0;
            was_act[i] = 1'b0;
        end
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        foreach (items[i]) begin
            it = items[i];
            g = (i > 40 && i < 90) ? 0 : gap_len();
            if (g != 0) begin
                s_tvalid <= 1'b0;
                repeat (g) @(posedge aclk);
            end
            s_tvalid <= 1'b1;
            s_tuser  <= it.func;
            s_tdata  <= {6'd0, it.ez, it.ey, it.ex, it.pz, it.py, it.px, it.shape, it.slot};
            @(posedge aclk);
            while (!s_tready) @(posedge aclk);
            predict_zone_results(it);
            if (it.has_exp) begin
                expected_q[$] = it.exp_res;
            end
        end
        s_tvalid <= 1'b0;
        sent_all = 1'b1;
    end

    // sink side: random stalls and one long hold-off, during which s_tready holds the source
    initial begin
        int g;
        wait (aresetn);
        repeat (60) @(posedge aclk);
        m_tready <= 1'b0;
        repeat (3000) @(posedge aclk);
        forever begin
            m_tready <= 1'b1;
            @(posedge aclk);
            g = ($urandom_range(0, 3) == 0) ? gap_len() : 0;
            if (g != 0) begin
                m_tready <= 1'b0;
                repeat (g) @(posedge aclk);
            end
        end
    end

    // result check
    always @(posedge aclk) begin
        zres_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tdata[3:0], m_tdata[4], m_tdata[21:5], m_tdata[22], m_tdata[23],
                   m_tdata[24], m_tdata[25], m_tlast};
            if (expected_q.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result transaction %h", got);
            end else begin
                want = expected_q.pop_front();
                if (got !== want) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch slot %0d:", want.slot,
                                 " exp pres=%b w=%0d a=%b e=%b x=%b acc=%b l=%b",
                                 want.present, want.weight, want.active,
                                 want.entered, want.exited, want.accepted, want.last,
                                 " got pres=%b w=%0d a=%b e=%b x=%b acc=%b l=%b",
                                 got.present, got.weight, got.active, got.entered,
                                 got.exited, got.accepted, got.last);
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        wait (sent_all);
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (2000) @(posedge aclk);
        if (errors == 0 && expected_q.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
